@@ rtl/core/gpns_pkg.sv @@
// ----------------------------------------------------------------------------
// gpns_pkg: shared types and constants for grid point neighbour smoothing
// Point, column and beat structures, divider constants and state encoding.
// ----------------------------------------------------------------------------
package gpns_pkg;

    localparam int COORD_BITS    = 16;
    localparam int MAX_COLS      = 64;
    localparam int MAX_ROWS      = 64;
    localparam int MIN_DIM       = 2;
    localparam int DIM_BITS      = 7;
    localparam int POS_BITS      = 6;
    localparam int CFG_IDX_BITS  = 1;

    localparam int COL_SUM_BITS  = COORD_BITS + 2;
    localparam int SUM_BITS      = COORD_BITS + 4;
    localparam int MAG_BITS      = COORD_BITS + 3;
    localparam int PROD_BITS     = 2 * MAG_BITS;
    localparam int DIV_SHIFT     = MAG_BITS + 2;
    localparam int Q0_BITS       = PROD_BITS - DIV_SHIFT;

    localparam int DIVISOR_BITS  = 4;
    localparam int DIVISOR_9     = 9;
    localparam int DIVISOR_6     = 6;
    localparam int HALF_9        = DIVISOR_9 / 2;
    localparam int HALF_6        = DIVISOR_6 / 2;
    localparam int RECIP_9       = (2 ** DIV_SHIFT) / DIVISOR_9;
    localparam int RECIP_6       = (2 ** DIV_SHIFT) / DIVISOR_6;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ROW_COUNT = 1'b0,
        CFG_COL_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIV,
        ST_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } point_t;

    typedef struct packed {
        point_t top;
        point_t mid;
        point_t bot;
    } col_t;

    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } cell_en_t;

    typedef struct packed {
        logic                         cmd;
        logic signed [COORD_BITS-1:0] in_x;
        logic signed [COORD_BITS-1:0] in_y;
    } in_beat_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic        [POS_BITS-1:0]   out_row;
        logic        [POS_BITS-1:0]   out_col;
        logic                         frame_last;
    } out_beat_t;

endpackage

@@ rtl/core/grid_point_neighbour_smoothing.sv @@
// ----------------------------------------------------------------------------
// grid_point_neighbour_smoothing: 3x3 mean filter over a raster point stream
// Line stores, a chain of three window column cells, and two rounding dividers.
// ----------------------------------------------------------------------------
// Takes one grid point (or flush beat) at a time in raster order and returns
// the rounded mean of its in-grid 3x3 neighbourhood, one row plus one point
// behind the input; corners come out as (0,0) and the first col_count+1 beats
// after reset or a register write return nothing. A beat that returns nothing
// is accepted, then goes through the registered line store read feeding the
// window shift. A beat that returns a point goes through accept, line store
// read, window sum, two divider stages, the cycle that sees the divider done,
// and the load of the result register, which waits while that register is
// still held by a stalled earlier result.
// A register write restarts the stream position but keeps line store contents.
// ----------------------------------------------------------------------------
module grid_point_neighbour_smoothing (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  gpns_pkg::in_beat_t                    item_data,
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output gpns_pkg::out_beat_t                   res_data,
    input  logic                                  cfg_wr_en,
    input  logic [gpns_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [gpns_pkg::DIM_BITS-1:0]         cfg_data
);

    gpns_pkg::state_t state_reg;
    gpns_pkg::state_t state_next;

    logic [gpns_pkg::DIM_BITS-1:0] row_count_reg;
    logic [gpns_pkg::DIM_BITS-1:0] row_count_next;
    logic [gpns_pkg::DIM_BITS-1:0] col_count_reg;
    logic [gpns_pkg::DIM_BITS-1:0] col_count_next;
    logic                          restart;

    logic [gpns_pkg::DIM_BITS-1:0] rows;
    logic [gpns_pkg::DIM_BITS-1:0] cols;
    logic [gpns_pkg::POS_BITS-1:0] rmax;
    logic [gpns_pkg::POS_BITS-1:0] cmax;

    logic [gpns_pkg::POS_BITS-1:0] in_col_reg;
    logic [gpns_pkg::POS_BITS-1:0] in_col_next;
    logic [gpns_pkg::DIM_BITS-1:0] fill_reg;
    logic [gpns_pkg::DIM_BITS-1:0] fill_next;
    logic [gpns_pkg::POS_BITS-1:0] out_row_reg;
    logic [gpns_pkg::POS_BITS-1:0] out_row_next;
    logic [gpns_pkg::POS_BITS-1:0] out_col_reg;
    logic [gpns_pkg::POS_BITS-1:0] out_col_next;

    gpns_pkg::point_t nw_reg;
    gpns_pkg::point_t ram_upper_rd;
    gpns_pkg::point_t ram_mid_rd;
    gpns_pkg::col_t   new_col;
    logic             emit_ok;

    logic item_stall_o;
    logic shift;
    logic store_wr;
    logic div_start;
    logic out_load;
    logic out_free;

    gpns_pkg::col_t     cell_col [3];
    gpns_pkg::cell_en_t cell_en  [3];
    logic signed [gpns_pkg::COL_SUM_BITS-1:0] cell_sx [3];
    logic signed [gpns_pkg::COL_SUM_BITS-1:0] cell_sy [3];

    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic corner;

    logic signed [gpns_pkg::SUM_BITS-1:0] sum_x_next;
    logic signed [gpns_pkg::SUM_BITS-1:0] sum_y_next;
    logic signed [gpns_pkg::SUM_BITS-1:0] sum_x_reg;
    logic signed [gpns_pkg::SUM_BITS-1:0] sum_y_reg;
    logic                                 is9_reg;
    logic                                 corner_reg;

    logic                                   div_done_x;
    logic                                   div_done_y;
    logic signed [gpns_pkg::COORD_BITS-1:0] quot_x;
    logic signed [gpns_pkg::COORD_BITS-1:0] quot_y;

    logic                res_valid_reg;
    logic                res_valid_next;
    gpns_pkg::out_beat_t res_data_reg;
    gpns_pkg::out_beat_t res_data_next;

    // ---------------- configuration ----------------
    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        restart        = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                gpns_pkg::CFG_ROW_COUNT:
                begin
                    row_count_next = cfg_data;
                    restart        = 1'b1;
                end
                gpns_pkg::CFG_COL_COUNT:
                begin
                    col_count_next = cfg_data;
                    restart        = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (row_count_reg < gpns_pkg::DIM_BITS'(gpns_pkg::MIN_DIM))
            rows = gpns_pkg::DIM_BITS'(gpns_pkg::MIN_DIM);
        else if (row_count_reg > gpns_pkg::DIM_BITS'(gpns_pkg::MAX_ROWS))
            rows = gpns_pkg::DIM_BITS'(gpns_pkg::MAX_ROWS);
        else
            rows = row_count_reg;

        if (col_count_reg < gpns_pkg::DIM_BITS'(gpns_pkg::MIN_DIM))
            cols = gpns_pkg::DIM_BITS'(gpns_pkg::MIN_DIM);
        else if (col_count_reg > gpns_pkg::DIM_BITS'(gpns_pkg::MAX_COLS))
            cols = gpns_pkg::DIM_BITS'(gpns_pkg::MAX_COLS);
        else
            cols = col_count_reg;
    end

    assign rmax = gpns_pkg::POS_BITS'(rows - 1'b1);
    assign cmax = gpns_pkg::POS_BITS'(cols - 1'b1);

    // ---------------- sequencer ----------------
    assign emit_ok  = fill_reg > cols;
    assign out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gpns_pkg::ST_IDLE:
                if (item_valid)
                    state_next = gpns_pkg::ST_READ;
            gpns_pkg::ST_READ:
                state_next = emit_ok ? gpns_pkg::ST_SUM : gpns_pkg::ST_IDLE;
            gpns_pkg::ST_SUM:
                state_next = gpns_pkg::ST_DIV;
            gpns_pkg::ST_DIV:
                state_next = gpns_pkg::ST_WAIT;
            gpns_pkg::ST_WAIT:
                if (div_done_x && div_done_y)
                    state_next = gpns_pkg::ST_OUT;
            gpns_pkg::ST_OUT:
                if (out_free)
                    state_next = gpns_pkg::ST_IDLE;
            default:
                state_next = gpns_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        item_stall_o = 1'b1;
        shift        = 1'b0;
        store_wr     = 1'b0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            gpns_pkg::ST_IDLE:
                item_stall_o = 1'b0;
            gpns_pkg::ST_READ:
            begin
                shift    = 1'b1;
                store_wr = 1'b1;
            end
            gpns_pkg::ST_SUM:
                item_stall_o = 1'b1;
            gpns_pkg::ST_DIV:
                div_start = 1'b1;
            gpns_pkg::ST_WAIT:
                item_stall_o = 1'b1;
            gpns_pkg::ST_OUT:
                out_load = out_free;
            default:
                item_stall_o = 1'b1;
        endcase
    end

    assign item_stall = item_stall_o;

    // ---------------- positions ----------------
    always_comb
    begin
        in_col_next  = in_col_reg;
        fill_next    = fill_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (restart)
        begin
            in_col_next  = '0;
            fill_next    = '0;
            out_row_next = '0;
            out_col_next = '0;
        end
        else
        begin
            if (shift)
            begin
                in_col_next = (in_col_reg == cmax) ? '0 : in_col_reg + 1'b1;
                if (!emit_ok)
                    fill_next = fill_reg + 1'b1;
            end
            if (out_load)
            begin
                if (out_col_reg == cmax)
                begin
                    out_col_next = '0;
                    out_row_next = (out_row_reg == rmax) ? '0 : out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gpns_pkg::ST_IDLE;
            row_count_reg <= gpns_pkg::DIM_BITS'(37);
            col_count_reg <= gpns_pkg::DIM_BITS'(37);
            in_col_reg    <= '0;
            fill_reg      <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            in_col_reg    <= in_col_next;
            fill_reg      <= fill_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // ---------------- incoming point ----------------
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall_o)
        begin
            if (item_data.cmd)
                nw_reg <= '0;
            else
            begin
                nw_reg.x <= item_data.in_x;
                nw_reg.y <= item_data.in_y;
            end
        end
    end

    // ---------------- line stores ----------------
    gpns_ram #(
        .WIDTH ($bits(gpns_pkg::point_t)),
        .DEPTH (gpns_pkg::MAX_COLS)
    ) u_store_upper (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (in_col_reg),
        .wr_data (ram_mid_rd),
        .rd_addr (in_col_reg),
        .rd_data (ram_upper_rd)
    );

    gpns_ram #(
        .WIDTH ($bits(gpns_pkg::point_t)),
        .DEPTH (gpns_pkg::MAX_COLS)
    ) u_store_middle (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (in_col_reg),
        .wr_data (nw_reg),
        .rd_addr (in_col_reg),
        .rd_data (ram_mid_rd)
    );

    // ---------------- window chain ----------------
    always_comb
    begin
        new_col.top = ram_upper_rd;
        new_col.mid = ram_mid_rd;
        new_col.bot = nw_reg;
    end

    always_comb
    begin
        top_ok   = out_row_reg != '0;
        bot_ok   = out_row_reg != rmax;
        left_ok  = out_col_reg != '0;
        right_ok = out_col_reg != cmax;
        corner   = (!top_ok || !bot_ok) && (!left_ok || !right_ok);
        cell_en[0] = '{top: top_ok && left_ok, mid: left_ok, bot: bot_ok && left_ok};
        cell_en[1] = '{top: top_ok, mid: 1'b1, bot: bot_ok};
        cell_en[2] = '{top: top_ok && right_ok, mid: right_ok, bot: bot_ok && right_ok};
    end

    for (genvar b = 0; b < 3; b++)
    begin : g_cell
        gpns_pkg::col_t col_in;
        if (b == 2)
        begin : g_head
            assign col_in = new_col;
        end
        else
        begin : g_link
            assign col_in = cell_col[b+1];
        end

        gpns_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clear   (restart),
            .shift   (shift),
            .col_in  (col_in),
            .en      (cell_en[b]),
            .col_out (cell_col[b]),
            .sum_x   (cell_sx[b]),
            .sum_y   (cell_sy[b])
        );
    end

    // ---------------- window sum ----------------
    always_comb
    begin
        sum_x_next = gpns_pkg::SUM_BITS'(cell_sx[0]) + gpns_pkg::SUM_BITS'(cell_sx[1])
                   + gpns_pkg::SUM_BITS'(cell_sx[2]);
        sum_y_next = gpns_pkg::SUM_BITS'(cell_sy[0]) + gpns_pkg::SUM_BITS'(cell_sy[1])
                   + gpns_pkg::SUM_BITS'(cell_sy[2]);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == gpns_pkg::ST_SUM)
        begin
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            is9_reg    <= top_ok && bot_ok && left_ok && right_ok;
            corner_reg <= corner;
        end
    end

    gpns_div u_div_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (sum_x_reg),
        .is9   (is9_reg),
        .done  (div_done_x),
        .quot  (quot_x)
    );

    gpns_div u_div_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .sum   (sum_y_reg),
        .is9   (is9_reg),
        .done  (div_done_y),
        .quot  (quot_y)
    );

    // ---------------- result register ----------------
    always_comb
    begin
        res_data_next            = res_data_reg;
        res_data_next.out_x      = corner_reg ? '0 : quot_x;
        res_data_next.out_y      = corner_reg ? '0 : quot_y;
        res_data_next.out_row    = out_row_reg;
        res_data_next.out_col    = out_col_reg;
        res_data_next.frame_last = (out_row_reg == rmax) && (out_col_reg == cmax);

        res_valid_next = res_valid_reg;
        if (out_load)
            res_valid_next = 1'b1;
        else if (res_valid_reg && !res_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_data_reg <= res_data_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

@@ rtl/core/gpns_ram.sv @@
// ----------------------------------------------------------------------------
// gpns_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gpns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/gpns_cell.sv @@
// ----------------------------------------------------------------------------
// gpns_cell: one column of the 3x3 window
// Holds three points, takes the column from its right-hand neighbour (the head
// cell takes the new column) on a shift, and gives the masked column sums of x and y.
// ----------------------------------------------------------------------------
module gpns_cell (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   clear,
    input  logic                                   shift,
    input  gpns_pkg::col_t                         col_in,
    input  gpns_pkg::cell_en_t                     en,
    output gpns_pkg::col_t                         col_out,
    output logic signed [gpns_pkg::COL_SUM_BITS-1:0] sum_x,
    output logic signed [gpns_pkg::COL_SUM_BITS-1:0] sum_y
);

    gpns_pkg::col_t col_reg;
    gpns_pkg::col_t col_next;

    always_comb
    begin
        col_next = col_reg;
        if (clear)
        begin
            col_next = '0;
        end
        else if (shift)
        begin
            col_next = col_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    always_comb
    begin
        sum_x = (en.top ? gpns_pkg::COL_SUM_BITS'(col_reg.top.x) : '0)
              + (en.mid ? gpns_pkg::COL_SUM_BITS'(col_reg.mid.x) : '0)
              + (en.bot ? gpns_pkg::COL_SUM_BITS'(col_reg.bot.x) : '0);
        sum_y = (en.top ? gpns_pkg::COL_SUM_BITS'(col_reg.top.y) : '0)
              + (en.mid ? gpns_pkg::COL_SUM_BITS'(col_reg.mid.y) : '0)
              + (en.bot ? gpns_pkg::COL_SUM_BITS'(col_reg.bot.y) : '0);
    end

    assign col_out = col_reg;

endmodule

@@ rtl/core/gpns_div.sv @@
// ----------------------------------------------------------------------------
// gpns_div: rounding mean divider
// Two-stage divide of a signed sum by 9 or 6, rounded to nearest with ties
// away from zero, using a reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module gpns_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [gpns_pkg::SUM_BITS-1:0] sum,
    input  logic                                 is9,
    output logic                                 done,
    output logic signed [gpns_pkg::COORD_BITS-1:0] quot
);

    logic                                 valid1_reg;
    logic                                 neg1_reg;
    logic                                 is9_1_reg;
    logic [gpns_pkg::MAG_BITS-1:0]        mag1_reg;
    logic [gpns_pkg::PROD_BITS-1:0]       prod1_reg;
    logic                                 done_reg;
    logic signed [gpns_pkg::COORD_BITS-1:0] quot_reg;

    logic                                 neg_next;
    logic [gpns_pkg::SUM_BITS-1:0]        abs_full;
    logic [gpns_pkg::MAG_BITS-1:0]        mag_next;
    logic [gpns_pkg::MAG_BITS-1:0]        recip;
    logic [gpns_pkg::PROD_BITS-1:0]       prod_next;

    logic [gpns_pkg::DIVISOR_BITS-1:0]    divisor;
    logic [gpns_pkg::Q0_BITS-1:0]         q0;
    logic [gpns_pkg::MAG_BITS-1:0]        qn;
    logic [gpns_pkg::MAG_BITS-1:0]        rem;
    logic [gpns_pkg::Q0_BITS-1:0]         q_fix;
    logic signed [gpns_pkg::Q0_BITS:0]    q_signed;
    logic signed [gpns_pkg::COORD_BITS-1:0] quot_next;

    // stage one: magnitude, rounding offset, reciprocal product
    always_comb
    begin
        neg_next  = sum[gpns_pkg::SUM_BITS-1];
        abs_full  = neg_next ? -sum : sum;
        mag_next  = abs_full[gpns_pkg::MAG_BITS-1:0]
                  + (is9 ? gpns_pkg::MAG_BITS'(gpns_pkg::HALF_9)
                         : gpns_pkg::MAG_BITS'(gpns_pkg::HALF_6));
        recip     = is9 ? gpns_pkg::MAG_BITS'(gpns_pkg::RECIP_9)
                        : gpns_pkg::MAG_BITS'(gpns_pkg::RECIP_6);
        prod_next = gpns_pkg::PROD_BITS'(mag_next) * gpns_pkg::PROD_BITS'(recip);
    end

    // stage two: correct the estimate by one, restore the sign
    always_comb
    begin
        divisor   = is9_1_reg ? gpns_pkg::DIVISOR_BITS'(gpns_pkg::DIVISOR_9)
                              : gpns_pkg::DIVISOR_BITS'(gpns_pkg::DIVISOR_6);
        q0        = prod1_reg[gpns_pkg::PROD_BITS-1:gpns_pkg::DIV_SHIFT];
        qn        = gpns_pkg::MAG_BITS'(q0) * gpns_pkg::MAG_BITS'(divisor);
        rem       = mag1_reg - qn;
        q_fix     = (rem >= gpns_pkg::MAG_BITS'(divisor)) ? q0 + 1'b1 : q0;
        q_signed  = neg1_reg ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
        quot_next = q_signed[gpns_pkg::COORD_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid1_reg <= start;
            done_reg   <= valid1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg1_reg  <= neg_next;
            is9_1_reg <= is9;
            mag1_reg  <= mag_next;
            prod1_reg <= prod_next;
        end
        if (valid1_reg)
        begin
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ rtl/core/gpns_checker.sv @@
// ----------------------------------------------------------------------------
// gpns_checker: port-level checks for grid point neighbour smoothing
// Watches the handshakes and result beats seen at the top level.
// ----------------------------------------------------------------------------
module gpns_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_stall,
    input logic                res_valid,
    input logic                res_stall,
    input gpns_pkg::out_beat_t res_data
);

    // hold a stalled result beat
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    // busy once a beat has been taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input taken again right after an accepted beat");

    // a result appears only out of a busy cycle
    a_res_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(item_stall))
        else $error("result raised without work in progress");

    // first and last points of the grid are corners
    a_corner_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.frame_last
                      || (res_data.out_row == '0 && res_data.out_col == '0))
        |-> res_data.out_x == '0 && res_data.out_y == '0)
        else $error("corner point not zero");

endmodule

bind grid_point_neighbour_smoothing gpns_checker u_gpns_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
);

@@ sim/grid_point_neighbour_smoothing_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_point_neighbour_smoothing_tb: self-checking bench for the 3x3 point smoother
// Streams raster grids of Q2.14 points and flush beats through the block under
// random gaps and back-pressure, predicts each smoothed point with its own model
// of the line stores and window, and compares every returned beat field by field.
// Grid geometry is reprogrammed between streams, out-of-range values included.
// ----------------------------------------------------------------------------
module grid_point_neighbour_smoothing_tb;

    import gpns_pkg::*;

    localparam logic CMD_POINT   = 1'b0;
    localparam logic CMD_FLUSH   = 1'b1;
    localparam int   ITEM_TARGET = 650;
    localparam int   CYCLE_LIMIT = 500000;
    localparam int   SETTLE      = 12;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    in_beat_t             item_data  = '0;
    logic                 res_valid;
    logic                 res_stall  = 1'b0;
    out_beat_t            res_data;
    logic                 cfg_wr_en  = 1'b0;
    cfg_reg_t             cfg_index  = CFG_ROW_COUNT;
    logic [DIM_BITS-1:0]  cfg_data   = '0;

    int send_gap_pct   = 16;
    int recv_stall_pct = 60;
    int fail_count     = 0;
    int beats_pushed   = 0;
    int cycle_count    = 0;

    // smoother state as seen from outside
    int        row_reg;
    int        col_reg;
    point_t    upper_line  [MAX_COLS];
    point_t    middle_line [MAX_COLS];
    point_t    window_pts  [3][3];
    int        in_col;
    int        out_idx;
    int        fill_cnt;
    out_beat_t smoothed_due [$];

    grid_point_neighbour_smoothing u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic int used_dim(int v, int hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void restart_stream();
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                window_pts[a][b] = '0;
        in_col   = 0;
        out_idx  = 0;
        fill_cnt = 0;
    endfunction

    function automatic void reset_smoother();
        row_reg = 37;
        col_reg = 37;
        for (int i = 0; i < MAX_COLS; i++)
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        restart_stream();
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rounded_mean(int s, int n);
        int m;
        int q;
        m = (s < 0) ? -s : s;
        q = (m + n / 2) / n;
        return COORD_BITS'((s < 0) ? -q : q);
    endfunction

    function automatic void predict_smoothed(in_beat_t beat);
        int        rows;
        int        cols;
        int        k;
        int        total;
        int        idx;
        int        r;
        int        c;
        int        rr;
        int        cc;
        int        sx;
        int        sy;
        int        n;
        bit        corner;
        point_t    nw;
        out_beat_t res;
        rows = used_dim(row_reg, MAX_ROWS);
        cols = used_dim(col_reg, MAX_COLS);
        k    = in_col % cols;
        nw   = '0;
        if (beat.cmd == CMD_POINT)
        begin
            nw.x = beat.in_x;
            nw.y = beat.in_y;
        end
        for (int a = 0; a < 3; a++)
        begin
            window_pts[a][0] = window_pts[a][1];
            window_pts[a][1] = window_pts[a][2];
        end
        window_pts[0][2] = upper_line[k];
        window_pts[1][2] = middle_line[k];
        window_pts[2][2] = nw;
        upper_line[k]    = middle_line[k];
        middle_line[k]   = nw;

        if (fill_cnt >= cols + 1)
        begin
            total = rows * cols;
            idx   = out_idx % total;
            r     = idx / cols;
            c     = idx % cols;
            sx    = 0;
            sy    = 0;
            n     = 0;
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3; b++)
                begin
                    rr = r - 1 + a;
                    cc = c - 1 + b;
                    if (rr >= 0 && rr < rows && cc >= 0 && cc < cols)
                    begin
                        sx += window_pts[a][b].x;
                        sy += window_pts[a][b].y;
                        n++;
                    end
                end
            corner = (r == 0 || r == rows - 1) && (c == 0 || c == cols - 1);
            res.out_x      = (corner || n == 0) ? '0 : rounded_mean(sx, n);
            res.out_y      = (corner || n == 0) ? '0 : rounded_mean(sy, n);
            res.out_row    = POS_BITS'(r);
            res.out_col    = POS_BITS'(c);
            res.frame_last = (idx == total - 1);
            smoothed_due   = {smoothed_due, res};
            out_idx = (idx + 1) % total;
        end
        else
            fill_cnt++;

        in_col = (k + 1 >= cols) ? 0 : k + 1;
    endfunction

    function automatic void compare_field(string field, logic signed [31:0] want,
                                          logic signed [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (smoothed_due.size() == 0)
            begin
                $display("%0t: unexpected result, actual x %0d y %0d row %0d col %0d last %0d",
                         $time, res_data.out_x, res_data.out_y, res_data.out_row,
                         res_data.out_col, res_data.frame_last);
                fail_count++;
            end
            else
            begin
                want = smoothed_due.pop_front();
                compare_field("out_x", want.out_x, res_data.out_x);
                compare_field("out_y", want.out_y, res_data.out_y);
                compare_field("out_row", want.out_row, res_data.out_row);
                compare_field("out_col", want.out_col, res_data.out_col);
                compare_field("frame_last", want.frame_last, res_data.frame_last);
            end
        end
    end

    function automatic logic signed [COORD_BITS-1:0] random_coord();
        int v;
        case ($urandom_range(5))
            0: v = 32'sh7FFF;
            1: v = -32768;
            2: v = int'($urandom_range(31)) - 16;
            default: v = $urandom;
        endcase
        return v[COORD_BITS-1:0];
    endfunction

    function automatic in_beat_t make_beat(logic cmd);
        in_beat_t beat;
        beat.cmd  = cmd;
        beat.in_x = random_coord();
        beat.in_y = random_coord();
        return beat;
    endfunction

    function automatic logic [DIM_BITS-1:0] edge_dim();
        case ($urandom_range(6))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd2;
            3: return 7'd63;
            4: return 7'd64;
            5: return 7'd65;
            default: return 7'd127;
        endcase
    endfunction

    task automatic push_point(in_beat_t beat);
        while ($urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= beat;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_smoothed(beat);
        beats_pushed++;
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (smoothed_due.size() != 0);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [DIM_BITS-1:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_ROW_COUNT)
            row_reg = value;
        else
            col_reg = value;
        restart_stream();
    endtask

    task automatic test_default_geometry();
        for (int i = 0; i < 45; i++)
            push_point(make_beat(($urandom_range(9) == 0) ? CMD_FLUSH : CMD_POINT));
    endtask

    task automatic test_min_grid();
        write_reg(CFG_ROW_COUNT, 7'd2);
        write_reg(CFG_COL_COUNT, 7'd2);
        push_point('{cmd: CMD_POINT, in_x: 16'sh7FFF, in_y: 16'sh8000});
        push_point('{cmd: CMD_POINT, in_x: 16'sh8000, in_y: 16'sh7FFF});
        push_point('{cmd: CMD_POINT, in_x: 16'sh7FFF, in_y: 16'sh7FFF});
        push_point('{cmd: CMD_POINT, in_x: 16'sh8000, in_y: 16'sh8000});
        for (int i = 0; i < 3; i++)
            push_point(make_beat(CMD_FLUSH));
    endtask

    task automatic test_saturated_grid();
        write_reg(CFG_ROW_COUNT, 7'd3);
        write_reg(CFG_COL_COUNT, 7'd3);
        for (int i = 0; i < 9; i++)
            push_point('{cmd: CMD_POINT, in_x: 16'sh7FFF, in_y: 16'sh8000});
        // flush data must be ignored
        for (int i = 0; i < 4; i++)
            push_point('{cmd: CMD_FLUSH, in_x: 16'sh1234, in_y: 16'sh8000});
    endtask

    task automatic stream_grid(logic [DIM_BITS-1:0] rv, logic [DIM_BITS-1:0] cv);
        int rows;
        int cols;
        int frame;
        int n;
        int pause_at;
        write_reg(CFG_ROW_COUNT, rv);
        write_reg(CFG_COL_COUNT, cv);
        rows  = used_dim(rv, MAX_ROWS);
        cols  = used_dim(cv, MAX_COLS);
        frame = rows * cols;
        if (frame <= 64)
            n = frame * $urandom_range(1, 3) + (($urandom_range(3) == 0) ?
                $urandom_range(1, cols) : 0);
        else
            n = $urandom_range(cols + 2, 100);
        pause_at = $urandom_range(n - 1);
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
                wait_drained();
            push_point(make_beat(($urandom_range(19) == 0) ? CMD_FLUSH : CMD_POINT));
        end
        for (int i = 0; i <= cols; i++)
            push_point(make_beat(CMD_FLUSH));
    endtask

    task automatic test_random_stream();
        for (int p = 0; p < 3; p++)
        begin
            send_gap_pct   = (p == 0) ? 16 : (p == 1) ? 60 : 0;
            recv_stall_pct = (p == 0) ? 60 : (p == 1) ? 16 : 0;
            case (p)
                0: stream_grid(7'd0, 7'd127);
                1: stream_grid(7'd127, 7'd1);
                default: stream_grid(7'd64, 7'd64);
            endcase
            while (beats_pushed < ITEM_TARGET * (p + 1) / 3)
            begin
                if ($urandom_range(4) == 0)
                    stream_grid(edge_dim(), edge_dim());
                else
                    stream_grid(DIM_BITS'($urandom_range(2, 8)),
                                DIM_BITS'($urandom_range(2, 8)));
            end
        end
    endtask

    initial
    begin
        reset_smoother();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_geometry();
        test_min_grid();
        test_saturated_grid();
        test_random_stream();

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && smoothed_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/gpns_pkg.sv
rtl/core/gpns_ram.sv
rtl/core/gpns_cell.sv
rtl/core/gpns_div.sv
rtl/core/grid_point_neighbour_smoothing.sv
rtl/core/gpns_checker.sv
sim/grid_point_neighbour_smoothing_tb.sv
